[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, skipped while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/egcd_pkg.sv]
`timescale 1ns / 1ps
package egcd_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAG_WIDTH   = 31;
  localparam int INDEX_WIDTH = 3;
  localparam logic [MAG_WIDTH-1:0] MAG_MAX = {MAG_WIDTH{1'b1}};

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] coefficient;
    logic [MAG_WIDTH-1:0]          gcd_result;
    logic [INDEX_WIDTH-1:0]        element_index;
    logic                          last_result;
    logic                          overflow;
  } result_t;

  typedef struct packed {
    logic                 start;
    logic [MAG_WIDTH-1:0] dividend;
    logic [MAG_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [MAG_WIDTH-1:0] quotient;
    logic [MAG_WIDTH-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RED_RD,
    ST_RED_CHK,
    ST_DIV,
    ST_ROW_RD,
    ST_ROW_MUL,
    ST_ROW_WR,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

endpackage

[sv/egcd_div.sv]
`timescale 1ns / 1ps
module egcd_div (
  input  logic                clk,
  input  logic                rst,
  input  egcd_pkg::div_req_t  req,
  output egcd_pkg::div_rsp_t  rsp
);
  import egcd_pkg::*;

  localparam int SW = $clog2(MAG_WIDTH);

  logic                 active;
  logic                 done;
  logic [SW-1:0]        step;
  logic [MAG_WIDTH-1:0] rem;
  logic [MAG_WIDTH-1:0] quot;
  logic [MAG_WIDTH-1:0] dsr;
  logic [MAG_WIDTH:0]   trial;
  logic [MAG_WIDTH:0]   diff;
  logic                 ge;
  logic [MAG_WIDTH-1:0] rem_next;

  always_comb begin
    trial    = {rem, quot[MAG_WIDTH-1]};
    ge       = trial >= {1'b0, dsr};
    diff     = trial - {1'b0, dsr};
    rem_next = ge ? diff[MAG_WIDTH-1:0] : trial[MAG_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        step   <= '0;
        rem    <= '0;
        quot   <= req.dividend;
        dsr    <= req.divisor;
      end else if (active) begin
        rem  <= rem_next;
        quot <= {quot[MAG_WIDTH-2:0], ge};
        step <= step + SW'(1);
        if (step == SW'(MAG_WIDTH - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quot;
  assign rsp.remainder = rem;

endmodule

[sv/vector_extended_gcd.sv]
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// item      start & !busy      in_item_t  (value, last_value)
// result    strobe, 1 cycle    result_t   (coefficient, gcd, index, last, overflow)
//
// Loading accepts one item per cycle; an item marked last starts the solve.
// Solve: identity fill of the n*n matrix, then per round a scan of all elements;
// a skipped element is read and checked, a reduced one is also divided in the
// 31-step divider and its coefficient row updated by read, multiply and write.
// Output: an overflow check over all elements, then one result per element.
// Reset is synchronous; results cannot be stalled and show for one cycle.
module vector_extended_gcd #(
  parameter int MAX_ELEMENTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  egcd_pkg::in_item_t item,
  output logic               strobe,
  output egcd_pkg::result_t  result
);
  import egcd_pkg::*;

  localparam int IW        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW        = $clog2(MAX_ELEMENTS + 1);
  localparam int MAT_DEPTH = MAX_ELEMENTS * MAX_ELEMENTS;
  localparam int MAW       = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;

  state_t state, state_next;

  logic [CW-1:0]        count;
  logic                 ovf_seen;
  logic [IW-1:0]        i, j, pivot;
  logic [MAG_WIDTH-1:0] least;
  logic [1:0]           nz;
  logic [MAG_WIDTH-1:0] q;
  logic signed [63:0]   prod;
  logic signed [63:0]   diff;
  logic signed [32:0]   q_s;

  // magnitude memory: {sign, magnitude}
  logic [VALUE_WIDTH-1:0] mag_mem [MAX_ELEMENTS];
  logic [VALUE_WIDTH-1:0] mag_q;
  logic                   mag_we;
  logic [IW-1:0]          mag_wa;
  logic [VALUE_WIDTH-1:0] mag_wd;

  logic signed [VALUE_WIDTH-1:0] mat_mem [MAT_DEPTH];
  logic signed [VALUE_WIDTH-1:0] ma_q, mb_q;
  logic                          mat_we;
  logic [MAW-1:0]                mat_wa, mat_ra, mat_rb;
  logic signed [VALUE_WIDTH-1:0] mat_wd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                   accept;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic                   in_clamp;
  logic [MAG_WIDTH-1:0]   in_mag31;
  logic                   last_i, last_j;
  logic [MAG_WIDTH-1:0]   cur_mag;
  logic [MAG_WIDTH-1:0]   least_next;
  logic [1:0]             nz_next;
  logic [IW-1:0]          pivot_next;
  logic                   skip;
  logic signed [VALUE_WIDTH-1:0] coef;

  function automatic logic [MAW-1:0] mat_addr(input logic [IW-1:0] row,
                                               input logic [IW-1:0] col);
    mat_addr = MAW'(int'(row) * MAX_ELEMENTS + int'(col));
  endfunction

  egcd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    accept   = start && (state == ST_IDLE);
    in_neg   = item.value[VALUE_WIDTH-1];
    in_mag   = in_neg ? (~item.value + VALUE_WIDTH'(1)) : item.value;
    in_clamp = in_mag[VALUE_WIDTH-1];
    in_mag31 = in_clamp ? MAG_MAX : in_mag[MAG_WIDTH-1:0];
    last_i   = (CW'(i) + CW'(1)) == count;
    last_j   = (CW'(j) + CW'(1)) == count;
    cur_mag  = mag_q[MAG_WIDTH-1:0];
    skip     = (i == pivot) || (cur_mag == '0);
    diff     = ma_q - prod;
    q_s      = $signed({2'b00, q});
    coef     = (nz == 2'd1) ? (mag_q[VALUE_WIDTH-1] ? -ma_q : ma_q) : '0;

    least_next = least;
    nz_next    = nz;
    pivot_next = pivot;
    if (cur_mag != '0) begin
      if (nz != 2'd2) nz_next = nz + 2'd1;
      if ((least == '0) || (cur_mag < least)) begin
        least_next = cur_mag;
        pivot_next = i;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (accept && item.last_value) state_next = ST_INIT;
      ST_INIT:     if (last_i && last_j) state_next = ST_SCAN_RD;
      ST_SCAN_RD:  state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (!last_i) state_next = ST_SCAN_RD;
        else if (nz_next == 2'd2) state_next = ST_RED_RD;
        else state_next = ST_CHK_RD;
      end
      ST_RED_RD:   state_next = ST_RED_CHK;
      ST_RED_CHK: begin
        if (!skip) state_next = ST_DIV;
        else if (last_i) state_next = ST_SCAN_RD;
        else state_next = ST_RED_RD;
      end
      ST_DIV:      if (div_rsp.done) state_next = ST_ROW_RD;
      ST_ROW_RD:   state_next = ST_ROW_MUL;
      ST_ROW_MUL:  state_next = ST_ROW_WR;
      ST_ROW_WR: begin
        if (!last_j) state_next = ST_ROW_RD;
        else if (last_i) state_next = ST_SCAN_RD;
        else state_next = ST_RED_RD;
      end
      ST_CHK_RD:   state_next = ST_CHK_EV;
      ST_CHK_EV:   state_next = last_i ? ST_EMIT_RD : ST_CHK_RD;
      ST_EMIT_RD:  state_next = ST_EMIT;
      ST_EMIT:     state_next = last_i ? ST_IDLE : ST_EMIT_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory ports and divider launch
  always_comb begin
    mag_we           = 1'b0;
    mag_wa           = i;
    mag_wd           = {mag_q[VALUE_WIDTH-1], div_rsp.remainder};
    mat_we           = 1'b0;
    mat_wa           = mat_addr(i, j);
    mat_wd           = diff[VALUE_WIDTH-1:0];
    mat_ra           = mat_addr(i, j);
    mat_rb           = mat_addr(pivot, j);
    div_req.start    = 1'b0;
    div_req.dividend = cur_mag;
    div_req.divisor  = least;
    case (state)
      ST_IDLE: begin
        mag_we = accept && (count < CW'(MAX_ELEMENTS));
        mag_wa = count[IW-1:0];
        mag_wd = {in_neg, in_mag31};
      end
      ST_INIT: begin
        mat_we = 1'b1;
        mat_wd = (i == j) ? VALUE_WIDTH'(1) : '0;
      end
      ST_RED_CHK: div_req.start = !skip;
      ST_DIV:     mag_we = div_rsp.done;
      ST_ROW_WR:  mat_we = 1'b1;
      ST_CHK_RD, ST_CHK_EV, ST_EMIT_RD, ST_EMIT: mat_ra = mat_addr(pivot, i);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mag_we) mag_mem[mag_wa] <= mag_wd;
    mag_q <= mag_mem[i];
  end

  always_ff @(posedge clk) begin
    if (mat_we) mat_mem[mat_wa] <= mat_wd;
    ma_q <= mat_mem[mat_ra];
    mb_q <= mat_mem[mat_rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      ovf_seen <= 1'b0;
      pivot    <= '0;
      strobe   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == ST_EMIT);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (count < CW'(MAX_ELEMENTS)) count <= count + CW'(1);
            if (in_clamp || (count >= CW'(MAX_ELEMENTS))) ovf_seen <= 1'b1;
            i <= '0;
            j <= '0;
          end
        end
        ST_INIT: begin
          if (last_j) begin
            j <= '0;
            if (last_i) begin
              i     <= '0;
              least <= '0;
              nz    <= '0;
              pivot <= '0;
            end else begin
              i <= i + IW'(1);
            end
          end else begin
            j <= j + IW'(1);
          end
        end
        ST_SCAN_CHK: begin
          least <= least_next;
          nz    <= nz_next;
          pivot <= pivot_next;
          i     <= last_i ? '0 : i + IW'(1);
        end
        ST_RED_CHK: begin
          if (skip) begin
            if (last_i) begin
              i     <= '0;
              least <= '0;
              nz    <= '0;
              pivot <= '0;
            end else begin
              i <= i + IW'(1);
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            q <= div_rsp.quotient;
            j <= '0;
          end
        end
        ST_ROW_MUL: prod <= q_s * mb_q;
        ST_ROW_WR: begin
          if (diff[63:VALUE_WIDTH-1] != {(65 - VALUE_WIDTH){diff[VALUE_WIDTH-1]}})
            ovf_seen <= 1'b1;
          if (last_j) begin
            j <= '0;
            if (last_i) begin
              i     <= '0;
              least <= '0;
              nz    <= '0;
              pivot <= '0;
            end else begin
              i <= i + IW'(1);
            end
          end else begin
            j <= j + IW'(1);
          end
        end
        ST_CHK_EV: begin
          // negating the most negative entry wraps
          if ((nz == 2'd1) && mag_q[VALUE_WIDTH-1] &&
              (ma_q == {1'b1, {(VALUE_WIDTH-1){1'b0}}}))
            ovf_seen <= 1'b1;
          i <= last_i ? '0 : i + IW'(1);
        end
        ST_EMIT: begin
          result.coefficient   <= coef;
          result.gcd_result    <= least;
          result.element_index <= INDEX_WIDTH'(i);
          result.last_result   <= last_i;
          result.overflow      <= ovf_seen;
          if (last_i) begin
            i        <= '0;
            count    <= '0;
            ovf_seen <= 1'b0;
          end else begin
            i <= i + IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

[sv/egcd_check.sv]
`timescale 1ns / 1ps
module egcd_check (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input egcd_pkg::result_t result
);
  `include "assert_macros.svh"

  // a fresh beat never lands on the next cycle's result
  `ASSERT_NEXT(a_accept_no_result, clk, rst, start && !busy, !strobe)
  // more results of the vector follow, so the block stays busy
  `ASSERT_NEXT(a_more_busy, clk, rst, strobe && !result.last_result, busy)
  // the final result frees the block at once
  `ASSERT_SAME(a_last_free, clk, rst, strobe && result.last_result, !busy)
  // reset leaves no result on the port
  `ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !strobe)

endmodule

bind vector_extended_gcd egcd_check u_egcd_check (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);
